// File: sv/rcfd_pkg.sv
// shared constants, types and decode functions for the command frame decoder
package rcfd_pkg;

	localparam int unsigned FRAME_LENGTH  = 19;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned PAYLOAD_DEPTH = 13;
	localparam int unsigned SLOT_W        = 4;

	localparam logic [POS_W-1:0] POS_WAIT = POS_W'(FRAME_LENGTH);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);

	// frame positions
	localparam logic [POS_W-1:0] POS_START       = 5'd0;
	localparam logic [POS_W-1:0] POS_SERVO1      = 5'd1;
	localparam logic [POS_W-1:0] POS_SERVO2      = 5'd2;
	localparam logic [POS_W-1:0] POS_MARK_L      = 5'd3;
	localparam logic [POS_W-1:0] POS_LED         = 5'd4;
	localparam logic [POS_W-1:0] POS_MARK_A      = 5'd5;
	localparam logic [POS_W-1:0] POS_LASER       = 5'd6;
	localparam logic [POS_W-1:0] POS_MARK_V      = 5'd7;
	localparam logic [POS_W-1:0] POS_WHEEL_FIRST = 5'd8;
	localparam logic [POS_W-1:0] POS_WHEEL_LAST  = 5'd15;
	localparam logic [POS_W-1:0] POS_MARK_R      = 5'd16;
	localparam logic [POS_W-1:0] POS_BUZZER      = 5'd17;
	localparam logic [POS_W-1:0] POS_END         = 5'd18;

	// marker bytes
	localparam logic [7:0] MARK_S  = 8'h53;
	localparam logic [7:0] MARK_L  = 8'h4C;
	localparam logic [7:0] MARK_A  = 8'h41;
	localparam logic [7:0] MARK_V  = 8'h56;
	localparam logic [7:0] MARK_R  = 8'h52;
	localparam logic [7:0] MARK_NL = 8'h0A;

	// payload slots
	localparam logic [SLOT_W-1:0] SLOT_SERVO1      = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_SERVO2      = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_LED         = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_LASER       = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_WHEEL_FIRST = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_BUZZER      = 4'd12;

	localparam logic [15:0] SCALE_RESET = 16'd1000;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} marker_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] idx;
	} slot_t;

	typedef struct packed {
		logic                               emit;
		logic [PAYLOAD_DEPTH-1:0][7:0]      payload;
	} frame_out_t;

	function automatic marker_t marker_of(input logic [POS_W-1:0] pos);
		marker_t r;
		r.hit = 1'b1;
		unique case (pos)
			POS_START:  r.value = MARK_S;
			POS_MARK_L: r.value = MARK_L;
			POS_MARK_A: r.value = MARK_A;
			POS_MARK_V: r.value = MARK_V;
			POS_MARK_R: r.value = MARK_R;
			POS_END:    r.value = MARK_NL;
			default: begin
				r.hit   = 1'b0;
				r.value = '0;
			end
		endcase
		return r;
	endfunction

	function automatic slot_t slot_of(input logic [POS_W-1:0] pos);
		slot_t r;
		r.hit = 1'b1;
		unique case (pos)
			POS_SERVO1: r.idx = SLOT_SERVO1;
			POS_SERVO2: r.idx = SLOT_SERVO2;
			POS_LED:    r.idx = SLOT_LED;
			POS_LASER:  r.idx = SLOT_LASER;
			POS_BUZZER: r.idx = SLOT_BUZZER;
			default: begin
				if (pos >= POS_WHEEL_FIRST && pos <= POS_WHEEL_LAST) begin
					r.idx = SLOT_W'(pos - POS_WHEEL_FIRST) + SLOT_WHEEL_FIRST;
				end else begin
					r.hit = 1'b0;
					r.idx = '0;
				end
			end
		endcase
		return r;
	endfunction

	// sign-magnitude 10.5 velocity times scale, /32 toward zero, saturated
	function automatic logic signed [15:0] scaled_speed(
		input logic [7:0]  hi,
		input logic [7:0]  lo,
		input logic [15:0] scale
	);
		logic [14:0] mag;
		logic [30:0] prod;
		logic [25:0] q;
		logic [15:0] r;
		mag  = {hi[6:0], lo};
		prod = 31'(mag) * 31'(scale);
		q    = prod[30:5];
		if (!hi[7]) begin
			r = (q > 26'd32767) ? 16'h7FFF : q[15:0];
		end else begin
			r = (q > 26'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
		end
		return signed'(r);
	endfunction

endpackage

// File: sv/robot_command_frame_decoder.sv
// top level of the robot command frame decoder
//
// Byte channel: rx_byte and frame_start with byte_valid/byte_stall. A word is
// taken at a clock edge with byte_valid high and byte_stall low. frame_start
// marks position zero and always restarts the frame.
// Result channel: result_valid/result_stall with the servo, LED, laser,
// buzzer and four wheel speed fields, one word per well-formed frame,
// issued with the last frame byte. Bad frames and stray bytes give nothing.
// cfg_write_en/cfg_write_data write speed_scale; write it only while idle.
// The last byte lands in the input register at the edge that takes it; the
// result register loads as that byte leaves the input register, which a
// held result under stall can delay. Bytes are taken one per cycle while
// byte_stall is low; the path is the 15x16 velocity multiply and saturation.
// Reset: frame tracking waits for a start byte, speed_scale returns to 1000,
// no result is pending.
// Stall: a stalled result holds; byte_stall rises only while a result is
// held and a byte sits in the input register, so up to one byte is buffered.
module robot_command_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic               cfg_write_en,
	input  logic [15:0]        cfg_write_data,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         servo_one_angle,
	output logic [7:0]         servo_two_angle,
	output logic [7:0]         led_level,
	output logic [7:0]         laser_level,
	output logic [7:0]         buzzer_level,
	output logic signed [15:0] speed_front_left,
	output logic signed [15:0] speed_front_right,
	output logic signed [15:0] speed_back_left,
	output logic signed [15:0] speed_back_right
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  start_s1;
	logic [15:0]           scale_q;
	logic                  room;
	logic                  advance;
	logic                  accept;
	rcfd_pkg::frame_out_t  frame;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			scale_q  <= rcfd_pkg::SCALE_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_write_en) begin
				scale_q <= cfg_write_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	rcfd_frame_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_data (data_s1),
		.start   (start_s1),
		.frame   (frame)
	);

	rcfd_result_stage u_result (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame             (frame),
		.scale             (scale_q),
		.result_stall      (result_stall),
		.room              (room),
		.result_valid      (result_valid),
		.servo_one_angle   (servo_one_angle),
		.servo_two_angle   (servo_two_angle),
		.led_level         (led_level),
		.laser_level       (laser_level),
		.buzzer_level      (buzzer_level),
		.speed_front_left  (speed_front_left),
		.speed_front_right (speed_front_right),
		.speed_back_left   (speed_back_left),
		.speed_back_right  (speed_back_right)
	);

endmodule

// File: sv/rcfd_frame_track.sv
// frame position tracking, marker checks and payload capture
module rcfd_frame_track (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_data,
	input  logic                    start,
	output rcfd_pkg::frame_out_t    frame
);

	logic [rcfd_pkg::POS_W-1:0] pos_q;
	logic                       good_q;
	logic [7:0]                 store_q [rcfd_pkg::PAYLOAD_DEPTH];

	logic                       active;
	logic [rcfd_pkg::POS_W-1:0] cur_pos;
	logic                       is_last;
	logic                       good_next;
	rcfd_pkg::marker_t          mk;
	rcfd_pkg::slot_t            sl;

	always_comb begin
		// bytes outside a frame are dropped unless they start one
		active    = step && (start || pos_q < rcfd_pkg::POS_WAIT);
		cur_pos   = start ? rcfd_pkg::POS_START : pos_q;
		mk        = rcfd_pkg::marker_of(cur_pos);
		sl        = rcfd_pkg::slot_of(cur_pos);
		is_last   = (cur_pos == rcfd_pkg::POS_LAST);
		good_next = (start || good_q) && !(mk.hit && rx_data != mk.value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= rcfd_pkg::POS_WAIT;
			good_q <= 1'b0;
		end else if (active) begin
			good_q <= good_next;
			pos_q  <= is_last ? rcfd_pkg::POS_WAIT : cur_pos + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (active && sl.hit) begin
			store_q[sl.idx] <= rx_data;
		end
	end

	always_comb begin
		frame.emit = active && is_last && good_next;
		for (int i = 0; i < rcfd_pkg::PAYLOAD_DEPTH; i++) begin
			frame.payload[i] = store_q[i];
		end
	end

endmodule

// File: sv/rcfd_result_stage.sv
// speed scaling and the output result register
module rcfd_result_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcfd_pkg::frame_out_t    frame,
	input  logic [15:0]             scale,
	input  logic                    result_stall,
	output logic                    room,
	output logic                    result_valid,
	output logic [7:0]              servo_one_angle,
	output logic [7:0]              servo_two_angle,
	output logic [7:0]              led_level,
	output logic [7:0]              laser_level,
	output logic [7:0]              buzzer_level,
	output logic signed [15:0]      speed_front_left,
	output logic signed [15:0]      speed_front_right,
	output logic signed [15:0]      speed_back_left,
	output logic signed [15:0]      speed_back_right
);

	logic                result_valid_q;
	logic [7:0]          servo1_s2, servo2_s2, led_s2, laser_s2, buzzer_s2;
	logic signed [15:0]  fl_s2, fr_s2, bl_s2, br_s2;
	logic signed [15:0]  fl_d, fr_d, bl_d, br_d;

	localparam int unsigned W = rcfd_pkg::SLOT_WHEEL_FIRST;

	always_comb begin
		fl_d = rcfd_pkg::scaled_speed(frame.payload[W],     frame.payload[W + 1], scale);
		fr_d = rcfd_pkg::scaled_speed(frame.payload[W + 2], frame.payload[W + 3], scale);
		bl_d = rcfd_pkg::scaled_speed(frame.payload[W + 4], frame.payload[W + 5], scale);
		br_d = rcfd_pkg::scaled_speed(frame.payload[W + 6], frame.payload[W + 7], scale);
	end

	assign room = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (frame.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// emit is only raised when room is up, so a held word is never overwritten
	always_ff @(posedge clk) begin
		if (frame.emit) begin
			servo1_s2 <= frame.payload[rcfd_pkg::SLOT_SERVO1];
			servo2_s2 <= frame.payload[rcfd_pkg::SLOT_SERVO2];
			led_s2    <= frame.payload[rcfd_pkg::SLOT_LED];
			laser_s2  <= frame.payload[rcfd_pkg::SLOT_LASER];
			buzzer_s2 <= frame.payload[rcfd_pkg::SLOT_BUZZER];
			fl_s2     <= fl_d;
			fr_s2     <= fr_d;
			bl_s2     <= bl_d;
			br_s2     <= br_d;
		end
	end

	assign result_valid      = result_valid_q;
	assign servo_one_angle   = servo1_s2;
	assign servo_two_angle   = servo2_s2;
	assign led_level         = led_s2;
	assign laser_level       = laser_s2;
	assign buzzer_level      = buzzer_s2;
	assign speed_front_left  = fl_s2;
	assign speed_front_right = fr_s2;
	assign speed_back_left   = bl_s2;
	assign speed_back_right  = br_s2;

endmodule

// File: sv/rcfd_checker.sv
// port-level checks for the command frame decoder, bound to the top level
module rcfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic [7:0]         rx_byte,
	input logic               frame_start,
	input logic               byte_valid,
	input logic               byte_stall,
	input logic               cfg_write_en,
	input logic [15:0]        cfg_write_data,
	input logic               result_valid,
	input logic               result_stall,
	input logic [7:0]         servo_one_angle,
	input logic [7:0]         servo_two_angle,
	input logic [7:0]         led_level,
	input logic [7:0]         laser_level,
	input logic [7:0]         buzzer_level,
	input logic signed [15:0] speed_front_left,
	input logic signed [15:0] speed_front_right,
	input logic signed [15:0] speed_back_left,
	input logic signed [15:0] speed_back_right
);

	// a held result word keeps its valid and its servo one, buzzer, front left and back right fields
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(servo_one_angle)
			&& $stable(buzzer_level) && $stable(speed_front_left)
			&& $stable(speed_back_right))
		else $error("stalled result word changed");

	// input backpressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid && result_stall)
		else $error("byte_stall without a held result");

	// a fresh result follows a taken byte that was not a frame start
	// (input register, then result register)
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && !byte_stall && !frame_start, 2))
		else $error("result without a closing frame byte");

endmodule

bind robot_command_frame_decoder rcfd_checker u_rcfd_checker (.*);

// File: tb/tb_robot_command_frame_decoder.sv
// self-checking testbench for the robot command frame decoder
module tb_robot_command_frame_decoder;
	import rcfd_pkg::*;

	localparam int SETTLE_CYCLES  = 6;
	localparam int STALL_LIMIT    = 1000;
	localparam int FRAMES_PER_SET = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} serial_word_t;

	typedef struct {
		logic [7:0]        servo_one;
		logic [7:0]        servo_two;
		logic [7:0]        led;
		logic [7:0]        laser;
		logic [7:0]        buzzer;
		logic signed [15:0] front_left;
		logic signed [15:0] front_right;
		logic signed [15:0] back_left;
		logic signed [15:0] back_right;
	} robot_cmd_t;

	typedef logic [7:0] frame_image_t [FRAME_LENGTH];

	logic               clk;
	logic               arst_n = 1'b0;
	logic [7:0]         rx_byte = '0;
	logic               frame_start = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_stall;
	logic               cfg_write_en = 1'b0;
	logic [15:0]        cfg_write_data = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [7:0]         servo_one_angle;
	logic [7:0]         servo_two_angle;
	logic [7:0]         led_level;
	logic [7:0]         laser_level;
	logic [7:0]         buzzer_level;
	logic signed [15:0] speed_front_left;
	logic signed [15:0] speed_front_right;
	logic signed [15:0] speed_back_left;
	logic signed [15:0] speed_back_right;

	robot_command_frame_decoder dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_byte           (rx_byte),
		.frame_start       (frame_start),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.cfg_write_en      (cfg_write_en),
		.cfg_write_data    (cfg_write_data),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.servo_one_angle   (servo_one_angle),
		.servo_two_angle   (servo_two_angle),
		.led_level         (led_level),
		.laser_level       (laser_level),
		.buzzer_level      (buzzer_level),
		.speed_front_left  (speed_front_left),
		.speed_front_right (speed_front_right),
		.speed_back_left   (speed_back_left),
		.speed_back_right  (speed_back_right)
	);

	serial_word_t pending_words[$];
	robot_cmd_t   expected_cmds[$];
	int           mismatches = 0;

	// decoder state as the testbench sees it
	logic [15:0]    scale_now = SCALE_RESET;
	logic [POS_W-1:0] frame_pos = POS_WAIT;
	bit             markers_ok = 1'b0;
	logic [7:0]     frame_seen [FRAME_LENGTH];

	logic [POS_W-1:0] marker_spots [6] =
		'{POS_START, POS_MARK_L, POS_MARK_A, POS_MARK_V, POS_MARK_R, POS_END};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// 10.5 sign-magnitude velocity to saturated wheel speed
	function automatic logic signed [15:0] wheel_speed(input logic [7:0] hi, input logic [7:0] lo);
		longint q;
		q = longint'({hi[6:0], lo}) * longint'(scale_now) / 32;
		if (hi[7])
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return 16'(q);
	endfunction

	task automatic decode_word(input logic [7:0] b, input logic sof);
		logic [POS_W-1:0] p;
		logic [7:0]       want;
		bit               is_marker;
		robot_cmd_t       cmd;
		if (sof) begin
			p = POS_START;
			markers_ok = 1'b1;
		end else if (frame_pos >= POS_WAIT) begin
			return;
		end else begin
			p = frame_pos;
		end
		is_marker = 1'b1;
		want = '0;
		case (p)
			POS_START:  want = MARK_S;
			POS_MARK_L: want = MARK_L;
			POS_MARK_A: want = MARK_A;
			POS_MARK_V: want = MARK_V;
			POS_MARK_R: want = MARK_R;
			POS_END:    want = MARK_NL;
			default:    is_marker = 1'b0;
		endcase
		if (is_marker && b != want)
			markers_ok = 1'b0;
		frame_seen[p] = b;
		frame_pos = p + 1'b1;
		if (p != POS_LAST)
			return;
		frame_pos = POS_WAIT;
		if (!markers_ok)
			return;
		cmd.servo_one   = frame_seen[POS_SERVO1];
		cmd.servo_two   = frame_seen[POS_SERVO2];
		cmd.led         = frame_seen[POS_LED];
		cmd.laser       = frame_seen[POS_LASER];
		cmd.buzzer      = frame_seen[POS_BUZZER];
		cmd.front_left  = wheel_speed(frame_seen[POS_WHEEL_FIRST], frame_seen[POS_WHEEL_FIRST + 1]);
		cmd.front_right = wheel_speed(frame_seen[POS_WHEEL_FIRST + 2], frame_seen[POS_WHEEL_FIRST + 3]);
		cmd.back_left   = wheel_speed(frame_seen[POS_WHEEL_FIRST + 4], frame_seen[POS_WHEEL_FIRST + 5]);
		cmd.back_right  = wheel_speed(frame_seen[POS_WHEEL_FIRST + 6], frame_seen[POS_WHEEL_FIRST + 7]);
		expected_cmds.push_back(cmd);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// byte driver
	int gap_left = 0;
	bit calm_in = 1'b0;
	always @(posedge clk) begin : drive_words
		bit           take;
		serial_word_t w;
		take = byte_valid && !byte_stall;
		if (take) begin
			decode_word(rx_byte, frame_start);
			gap_left = calm_in ? 0 : $urandom_range(0, 16);
		end
		if (arst_n && (take || !byte_valid)) begin
			if (gap_left > 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				if ($urandom_range(0, 63) == 0)
					calm_in = !calm_in;
				rx_byte     <= w.data;
				frame_start <= w.sof;
				byte_valid  <= 1'b1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// result monitor
	int stall_left = 0;
	bit calm_out = 1'b0;
	always @(posedge clk) begin : watch_results
		robot_cmd_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("result word with no command expected");
					mismatches++;
				end else begin
					e = expected_cmds.pop_front();
					check_field("servo_one_angle", e.servo_one, servo_one_angle);
					check_field("servo_two_angle", e.servo_two, servo_two_angle);
					check_field("led_level", e.led, led_level);
					check_field("laser_level", e.laser, laser_level);
					check_field("buzzer_level", e.buzzer, buzzer_level);
					check_field("speed_front_left", e.front_left, speed_front_left);
					check_field("speed_front_right", e.front_right, speed_front_right);
					check_field("speed_back_left", e.back_left, speed_back_left);
					check_field("speed_back_right", e.back_right, speed_back_right);
				end
				if ($urandom_range(0, 15) == 0)
					calm_out = !calm_out;
				stall_left = calm_out ? 0 : $urandom_range(0, 16);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_stall <= (stall_left != 0);
		end
	end

	// watchdog on cycles with no word moving
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic frame_image_t make_frame(
		input logic [7:0]  s1,
		input logic [7:0]  s2,
		input logic [7:0]  led,
		input logic [7:0]  laser,
		input logic [7:0]  buzz,
		input logic [15:0] fl,
		input logic [15:0] fr,
		input logic [15:0] bl,
		input logic [15:0] br
	);
		frame_image_t f;
		f[POS_START]           = MARK_S;
		f[POS_SERVO1]          = s1;
		f[POS_SERVO2]          = s2;
		f[POS_MARK_L]          = MARK_L;
		f[POS_LED]             = led;
		f[POS_MARK_A]          = MARK_A;
		f[POS_LASER]           = laser;
		f[POS_MARK_V]          = MARK_V;
		{f[POS_WHEEL_FIRST], f[POS_WHEEL_FIRST + 1]} = fl;
		{f[POS_WHEEL_FIRST + 2], f[POS_WHEEL_FIRST + 3]} = fr;
		{f[POS_WHEEL_FIRST + 4], f[POS_WHEEL_FIRST + 5]} = bl;
		{f[POS_WHEEL_FIRST + 6], f[POS_WHEEL_FIRST + 7]} = br;
		f[POS_MARK_R]          = MARK_R;
		f[POS_BUZZER]          = buzz;
		f[POS_END]             = MARK_NL;
		return f;
	endfunction

	// mix of arbitrary, modest and near-saturation magnitudes
	function automatic logic [15:0] random_velocity();
		int          k;
		logic [14:0] mag;
		case ($urandom_range(0, 2))
			0: mag = 15'($urandom);
			1: mag = 15'($urandom_range(0, 2047));
			default: begin
				k = (scale_now == 0) ? 0 : (32768 * 32) / int'(scale_now);
				k = k + int'($urandom_range(0, 6)) - 3;
				if (k < 0)
					k = 0;
				if (k > 32767)
					k = 32767;
				mag = 15'(k);
			end
		endcase
		return {1'($urandom), mag};
	endfunction

	function automatic frame_image_t random_frame();
		return make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			random_velocity(), random_velocity(), random_velocity(), random_velocity());
	endfunction

	task automatic queue_frame(input frame_image_t f, input int count);
		for (int i = 0; i < count; i++)
			pending_words.push_back('{data: f[i], sof: (i == 0)});
	endtask

	task automatic queue_stray(input logic [7:0] b);
		pending_words.push_back('{data: b, sof: 1'b0});
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || byte_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(input logic [15:0] v);
		@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		scale_now = v;
	endtask

	task automatic queue_random_frames(input int n);
		frame_image_t f;
		int           r;
		for (int i = 0; i < n; i++) begin
			f = random_frame();
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_frame(f, FRAME_LENGTH);
			end else if (r < 82) begin
				f[marker_spots[$urandom_range(0, 5)]] ^= 8'($urandom_range(1, 255));
				queue_frame(f, FRAME_LENGTH);
			end else if (r < 92) begin
				// cut short, the next start drops it
				queue_frame(f, $urandom_range(1, FRAME_LENGTH - 1));
			end else begin
				repeat ($urandom_range(1, 4))
					pending_words.push_back('{data: 8'($urandom), sof: ($urandom_range(0, 3) == 0)});
			end
		end
	endtask

	initial begin : stimulus
		frame_image_t f;
		logic [15:0]  scale_plan [7];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset scale
		queue_stray(MARK_S);
		queue_frame(make_frame(8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF,
			16'h7FFF, 16'hFFFF, 16'h8000, 16'h8021), FRAME_LENGTH);
		f = make_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0001, 16'h8001, 16'h0020);
		queue_frame(f, 10);
		queue_frame(f, FRAME_LENGTH);
		for (int i = 0; i < 6; i++) begin
			f = make_frame(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'h0100, 16'h8100, 16'h0041, 16'h8041);
			f[marker_spots[i]] = ~f[marker_spots[i]];
			queue_frame(f, FRAME_LENGTH);
		end
		queue_stray(MARK_NL);
		queue_stray(8'hFF);
		queue_random_frames(FRAMES_PER_SET);
		drain();

		scale_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd32, 16'($urandom), 16'($urandom), SCALE_RESET};
		foreach (scale_plan[i]) begin
			write_scale(scale_plan[i]);
			f = make_frame(8'h01, 8'h80, 8'h7F, 8'hFE, 8'h11, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8001);
			queue_frame(f, FRAME_LENGTH);
			queue_random_frames(FRAMES_PER_SET);
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
